### rtl/core/ncc_pkg.sv
// Shared types and constants for the normalized cross-correlation core.
// Used by the accumulator front end, the queue, the multiplier and the back end.
`timescale 1ns / 1ps
package ncc_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned CountBits  = 17;
  localparam int unsigned SumBits    = 32;
  localparam int unsigned SqBits     = 48;
  localparam logic [CountBits-1:0] MaxElements = 17'd65536;

  // accumulator snapshot handed from the front end to the back end
  typedef struct packed {
    logic [CountBits-1:0] pair_count;
    logic [SumBits-1:0]   sum_first;
    logic [SumBits-1:0]   sum_second;
    logic [SqBits-1:0]    sum_cross;
    logic [SqBits-1:0]    sum_sq_first;
    logic [SqBits-1:0]    sum_sq_second;
  } acc_t;

  typedef enum logic [2:0] {
    OP_NSAB, OP_SASB, OP_NSAA, OP_SASA, OP_NSBB, OP_SBSB, OP_VAVB, OP_NN
  } mul_op_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_START, ST_MUL_WAIT, ST_CHECK, ST_DIV, ST_SQRT, ST_OUT
  } back_state_e;

endpackage

### rtl/core/ncc_fifo.sv
// Two-entry queue of accumulator snapshots between front and back end.
// Depends on ncc_pkg for acc_t.
`timescale 1ns / 1ps
module ncc_fifo import ncc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  acc_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output acc_t pop_data_o
);

  acc_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign full_o     = fill_q[1];
  assign valid_o    = (fill_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      fill_q <= fill_q + 2'd1;
      else if (pop_i && !push_i) fill_q <= fill_q - 2'd1;
    end
  end

endmodule

### rtl/core/ncc_mul.sv
// Sequential 64x64 unsigned multiplier built on one 32x32 product per cycle.
// Depends on ncc_pkg only by convention; standalone datapath.
`timescale 1ns / 1ps
module ncc_mul import ncc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] prod_o
);

  logic [63:0]  a_q, b_q;
  logic [63:0]  pp_q;
  logic [1:0]   pp_sh_q;
  logic [127:0] acc_q;
  logic [2:0]   step_q;
  logic         run_q, done_q;
  logic [31:0]  a_half, b_half;
  logic [127:0] pp_term;

  assign a_half  = step_q[1] ? a_q[63:32] : a_q[31:0];
  assign b_half  = step_q[0] ? b_q[63:32] : b_q[31:0];
  assign pp_term = {64'd0, pp_q} << {pp_sh_q, 5'd0};
  assign done_o  = done_q;
  assign prod_o  = acc_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (run_q) begin
      if (step_q != 3'd4) begin
        pp_q    <= a_half * b_half;
        pp_sh_q <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
      end
      if (step_q != 3'd0) acc_q <= acc_q + pp_term;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= 3'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= 3'd0;
      end else if (run_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd4) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/ncc_front.sv
// Front end: accepts sample pairs, accumulates moments, queues a snapshot on the last pair.
// Depends on ncc_pkg for acc_t and the accumulator widths.
`timescale 1ns / 1ps
module ncc_front import ncc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [SampleBits-1:0] sample_a_i,
  input  logic [SampleBits-1:0] sample_b_i,
  input  logic                  last_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output acc_t                  push_data_o
);

  acc_t acc_q, acc_d;
  logic accept;
  logic [31:0] prod_ab, prod_aa, prod_bb;

  assign ready_o = !q_full_i;
  assign accept  = valid_i && ready_o;
  assign prod_ab = sample_a_i * sample_b_i;
  assign prod_aa = sample_a_i * sample_a_i;
  assign prod_bb = sample_b_i * sample_b_i;

  always_comb begin
    acc_d = acc_q;
    if (acc_q.pair_count < MaxElements) begin
      acc_d.pair_count    = acc_q.pair_count + 17'd1;
      acc_d.sum_first     = acc_q.sum_first + {16'd0, sample_a_i};
      acc_d.sum_second    = acc_q.sum_second + {16'd0, sample_b_i};
      acc_d.sum_cross     = acc_q.sum_cross + {16'd0, prod_ab};
      acc_d.sum_sq_first  = acc_q.sum_sq_first + {16'd0, prod_aa};
      acc_d.sum_sq_second = acc_q.sum_sq_second + {16'd0, prod_bb};
    end
  end

  assign push_o      = accept && last_i;
  assign push_data_o = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (accept) begin
      // clear for the next run once the snapshot is queued
      acc_q <= last_i ? '0 : acc_d;
    end
  end

endmodule

### rtl/core/ncc_back.sv
// Back end: centered moments, correlation square by long division, integer root.
// Depends on ncc_pkg and ncc_mul; drives the registered result word.
`timescale 1ns / 1ps
module ncc_back import ncc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  acc_t        q_data_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_corr_o,
  output logic        out_deg_o
);

  back_state_e state_q, state_d;
  mul_op_e     mop_q;
  acc_t        e_q;
  logic [63:0]  t_q, num_q, va_q, vb_q;
  logic         neg_q;
  logic [127:0] p_q, rem_q;
  logic [30:0]  quo_q;
  logic [4:0]   cnt_q;
  logic [15:0]  root_q;
  logic [3:0]   bit_q;
  logic [15:0]  res_corr_q;
  logic         res_deg_q;
  logic         out_valid_q;
  logic [15:0]  out_corr_q;
  logic         out_deg_q;

  logic         mul_start, mul_done;
  logic [63:0]  op_a, op_b, m_lo;
  logic [127:0] mul_prod;
  logic [128:0] div_t;
  logic         div_ge;
  logic [15:0]  cand;
  logic [31:0]  cand_sq;
  logic [16:0]  qf;
  logic         out_free;

  ncc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  always_comb begin
    unique case (mop_q)
      OP_NSAB: begin op_a = {47'd0, e_q.pair_count}; op_b = {16'd0, e_q.sum_cross}; end
      OP_SASB: begin op_a = {32'd0, e_q.sum_first}; op_b = {32'd0, e_q.sum_second}; end
      OP_NSAA: begin op_a = {47'd0, e_q.pair_count}; op_b = {16'd0, e_q.sum_sq_first}; end
      OP_SASA: begin op_a = {32'd0, e_q.sum_first}; op_b = {32'd0, e_q.sum_first}; end
      OP_NSBB: begin op_a = {47'd0, e_q.pair_count}; op_b = {16'd0, e_q.sum_sq_second}; end
      OP_SBSB: begin op_a = {32'd0, e_q.sum_second}; op_b = {32'd0, e_q.sum_second}; end
      OP_VAVB: begin op_a = va_q; op_b = vb_q; end
      OP_NN:   begin op_a = num_q; op_b = num_q; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign m_lo     = mul_prod[63:0];
  assign div_t    = (cnt_q == 5'd0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign div_ge   = div_t >= {1'b0, p_q};
  assign cand     = root_q | (16'd1 << bit_q);
  assign cand_sq  = cand * cand;
  assign qf       = quo_q[30] ? 17'd32768 : {1'b0, root_q};
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (q_valid_i) state_d = ST_MUL_START;
      ST_MUL_START: state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          if (mop_q == OP_SBSB)    state_d = ST_CHECK;
          else if (mop_q == OP_NN) state_d = ST_DIV;
          else                     state_d = ST_MUL_START;
        end
      end
      ST_CHECK: begin
        if (va_q == '0 || vb_q == '0) state_d = ST_OUT;
        else                          state_d = ST_MUL_START;
      end
      ST_DIV:  if (cnt_q == 5'd30) state_d = ST_SQRT;
      ST_SQRT: if (bit_q == 4'd0) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o     = (state_q == ST_IDLE) && q_valid_i;
    mul_start = (state_q == ST_MUL_START);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mop_q <= OP_NSAB;
    end else begin
      if (state_q == ST_IDLE) begin
        mop_q <= OP_NSAB;
      end else if (state_q == ST_MUL_WAIT && mul_done && mop_q != OP_NN) begin
        mop_q <= mul_op_e'(mop_q + 3'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (q_valid_i) e_q <= q_data_i;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          case (mop_q) inside
            OP_NSAB, OP_NSAA, OP_NSBB: t_q <= m_lo;
            OP_SASB: begin
              neg_q <= t_q < m_lo;
              num_q <= (t_q < m_lo) ? (m_lo - t_q) : (t_q - m_lo);
            end
            OP_SASA: va_q <= t_q - m_lo;
            OP_SBSB: vb_q <= t_q - m_lo;
            OP_VAVB: p_q  <= mul_prod;
            default: begin
              rem_q <= mul_prod;
              quo_q <= '0;
              cnt_q <= 5'd0;
            end
          endcase
        end
      end
      ST_CHECK: begin
        res_corr_q <= '0;
        res_deg_q  <= 1'b1;
      end
      ST_DIV: begin
        // restoring step: one quotient bit of 2^30 * N^2 / (Va * Vb)
        rem_q  <= div_ge ? div_t[127:0] - p_q : div_t[127:0];
        quo_q  <= {quo_q[29:0], div_ge};
        cnt_q  <= cnt_q + 5'd1;
        root_q <= '0;
        bit_q  <= 4'd15;
      end
      ST_SQRT: begin
        if (cand_sq <= {1'b0, quo_q}) root_q <= cand;
        bit_q <= bit_q - 4'd1;
      end
      ST_OUT: ;
      default: ;
    endcase
    if (state_q == ST_SQRT && bit_q == 4'd0) begin
      res_deg_q <= 1'b0;
    end
  end

  // final root fixup is folded into the output load
  logic [16:0] root_fin;
  logic [15:0] corr_val;
  always_comb begin
    root_fin = qf;
    if (res_deg_q) begin
      corr_val = res_corr_q;
    end else if (neg_q) begin
      corr_val = 16'(17'h10000 - root_fin);
    end else if (root_fin > 17'd32767) begin
      corr_val = 16'd32767;
    end else begin
      corr_val = root_fin[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_corr_q <= corr_val;
      out_deg_q  <= res_deg_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_corr_o  = out_corr_q;
  assign out_deg_o   = out_deg_q;

endmodule

### rtl/core/normalized_cross_correlation_core.sv
// Zero-mean normalized cross-correlation of two sample streams, Q1.15 result.
// Accepts one sample pair per cycle while the snapshot queue has room. A run's
// result needs eight products on one 32x32 multiplier, a 31-step restoring
// division and a 16-step square root, or six products when a variance is zero.
// Two finished runs queue while the back end works. rst_ni asynchronously
// clears all control and accumulator state.
`timescale 1ns / 1ps
module normalized_cross_correlation_core import ncc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] sample_a, [31:16] sample_b
  input  logic        s_axis_tlast,  // last_pair
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [15:0] correlation
  output logic        m_axis_tuser   // degenerate
);

  logic q_full, q_push, q_pop, q_valid;
  acc_t q_wdata, q_rdata;

  ncc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .sample_a_i (s_axis_tdata[15:0]),
    .sample_b_i (s_axis_tdata[31:16]),
    .last_i     (s_axis_tlast),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .push_data_o(q_wdata)
  );

  ncc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_rdata)
  );

  ncc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_rdata),
    .pop_o      (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_corr_o (m_axis_tdata),
    .out_deg_o  (m_axis_tuser)
  );

endmodule
